/* rtl/php_pkg.sv */
// Shared types, constants and codes for the packet header parser.
package php_pkg;

    localparam int MAX_MESSAGES = 256;
    localparam int MSG_CNT_W    = 9;
    localparam int REM_W        = 9;
    localparam int FBC_W        = 2;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // flag byte bits
    localparam int FLAG_INTERVAL_BIT     = 0;
    localparam int FLAG_SENT_BIT         = 1;
    localparam int FLAG_MISSED_BIT       = 2;
    localparam int FLAG_SESSION_BIT      = 3;
    localparam int FLAG_PEER_SESSION_BIT = 4;

    // last byte index within multi-byte header fields
    localparam logic [FBC_W-1:0] SEQ_LAST_BYTE  = 2'd1;
    localparam logic [FBC_W-1:0] WORD_LAST_BYTE = 2'd3;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_MISSED  = 2'd1,
        KIND_MESSAGE = 2'd2,
        KIND_VERDICT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        VERDICT_OK        = 2'd0,
        VERDICT_TRUNCATED = 2'd1,
        VERDICT_TOO_MANY  = 2'd2,
        VERDICT_RSVD      = 2'd3
    } t_verdict;

    typedef enum logic [11:0] {
        PH_FLAG        = 12'h001,
        PH_SEQOBS      = 12'h002,
        PH_SEQ         = 12'h004,
        PH_SESSOBS     = 12'h008,
        PH_SESS        = 12'h010,
        PH_INTERVAL    = 12'h020,
        PH_UNSENT      = 12'h040,
        PH_MISSED_LEN  = 12'h080,
        PH_MISSED_BODY = 12'h100,
        PH_MSG_LEN     = 12'h200,
        PH_MSG_BODY    = 12'h400,
        PH_DRAIN       = 12'h800
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  seq_observed;
        logic [15:0] sequence_number;
        logic [31:0] peer_session;
        logic [31:0] session_id;
        logic [7:0]  interval;
        logic [7:0]  unsent_count;
        logic [7:0]  payload_byte;
        logic [7:0]  message_index;
        logic        end_of_sequence;
        t_verdict    verdict;
        logic        last_of_run;
    } t_result;

    // up to two results written into the output queue in one cycle
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

/* rtl/php_parser.sv */
// Per-byte parse state and result generation for the packet header parser.
module php_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output php_pkg::t_push      o_push
);
    import php_pkg::*;

    t_phase               r_phase,     n_phase;
    logic [FBC_W-1:0]     r_fbc,       n_fbc;
    logic [REM_W-1:0]     r_rem,       n_rem;
    logic [MSG_CNT_W-1:0] r_msg_count, n_msg_count;
    logic [7:0]           r_flags,     n_flags;
    logic [7:0]           r_seq_obs,   n_seq_obs;
    logic [15:0]          r_seq,       n_seq;
    logic [31:0]          r_sess_obs,  n_sess_obs;
    logic [31:0]          r_sess,      n_sess;
    logic [7:0]           r_interval,  n_interval;
    logic [7:0]           r_unsent,    n_unsent;
    t_verdict             r_err,       n_err;

    logic                 hdr_done;
    logic                 prim_v;
    t_result              prim;
    t_result              verd;

    // next present header field after 'from', else the first body phase
    function automatic t_phase hdr_next(input t_phase from, input logic [7:0] f);
        t_phase p;
        p = f[FLAG_MISSED_BIT] ? PH_MISSED_LEN : PH_MSG_LEN;
        if (from == PH_SEQ || from == PH_SESSOBS || from == PH_SESS
            || from == PH_INTERVAL) begin
            if (f[FLAG_SENT_BIT]) p = PH_UNSENT;
        end
        if (from == PH_SEQ || from == PH_SESSOBS || from == PH_SESS) begin
            if (f[FLAG_INTERVAL_BIT]) p = PH_INTERVAL;
        end
        if (from == PH_SEQ || from == PH_SESSOBS) begin
            if (f[FLAG_SESSION_BIT]) p = PH_SESS;
        end
        if (from == PH_SEQ) begin
            if (f[FLAG_PEER_SESSION_BIT]) p = PH_SESSOBS;
        end
        return p;
    endfunction

    always_comb begin
        n_phase     = r_phase;
        n_fbc       = r_fbc;
        n_rem       = r_rem;
        n_msg_count = r_msg_count;
        n_flags     = r_flags;
        n_seq_obs   = r_seq_obs;
        n_seq       = r_seq;
        n_sess_obs  = r_sess_obs;
        n_sess      = r_sess;
        n_interval  = r_interval;
        n_unsent    = r_unsent;
        n_err       = r_err;
        hdr_done    = 1'b0;
        prim_v      = 1'b0;
        prim        = '0;
        verd        = '0;

        case (r_phase)
            PH_FLAG: begin
                n_flags = i_byte;
                n_phase = PH_SEQOBS;
            end
            PH_SEQOBS: begin
                n_seq_obs = i_byte;
                n_fbc     = '0;
                n_phase   = PH_SEQ;
            end
            PH_SEQ: begin
                n_seq = {r_seq[7:0], i_byte};
                if (r_fbc >= SEQ_LAST_BYTE) begin
                    n_fbc    = '0;
                    n_phase  = hdr_next(PH_SEQ, r_flags);
                    hdr_done = (n_phase == PH_MISSED_LEN) || (n_phase == PH_MSG_LEN);
                end else begin
                    n_fbc = r_fbc + 1'b1;
                end
            end
            PH_SESSOBS: begin
                n_sess_obs = {r_sess_obs[23:0], i_byte};
                if (r_fbc == WORD_LAST_BYTE) begin
                    n_fbc    = '0;
                    n_phase  = hdr_next(PH_SESSOBS, r_flags);
                    hdr_done = (n_phase == PH_MISSED_LEN) || (n_phase == PH_MSG_LEN);
                end else begin
                    n_fbc = r_fbc + 1'b1;
                end
            end
            PH_SESS: begin
                n_sess = {r_sess[23:0], i_byte};
                if (r_fbc == WORD_LAST_BYTE) begin
                    n_fbc    = '0;
                    n_phase  = hdr_next(PH_SESS, r_flags);
                    hdr_done = (n_phase == PH_MISSED_LEN) || (n_phase == PH_MSG_LEN);
                end else begin
                    n_fbc = r_fbc + 1'b1;
                end
            end
            PH_INTERVAL: begin
                n_interval = i_byte;
                n_fbc      = '0;
                n_phase    = hdr_next(PH_INTERVAL, r_flags);
                hdr_done   = (n_phase == PH_MISSED_LEN) || (n_phase == PH_MSG_LEN);
            end
            PH_UNSENT: begin
                n_unsent = i_byte;
                n_fbc    = '0;
                n_phase  = hdr_next(PH_UNSENT, r_flags);
                hdr_done = 1'b1;
            end
            PH_MISSED_LEN: begin
                n_rem   = {1'b0, i_byte} + 1'b1;
                n_phase = PH_MISSED_BODY;
            end
            PH_MISSED_BODY: begin
                n_rem  = r_rem - REM_W'(r_rem != '0);
                prim_v = 1'b1;
                prim.kind            = KIND_MISSED;
                prim.payload_byte    = i_byte;
                prim.end_of_sequence = (n_rem == '0);
                if (n_rem == '0) n_phase = PH_MSG_LEN;
            end
            PH_MSG_LEN: begin
                if (r_msg_count >= MSG_CNT_W'(MAX_MESSAGES)) begin
                    n_err   = VERDICT_TOO_MANY;
                    n_phase = PH_DRAIN;
                end else begin
                    n_rem   = {1'b0, i_byte} + 1'b1;
                    n_phase = PH_MSG_BODY;
                end
            end
            PH_MSG_BODY: begin
                n_rem  = r_rem - REM_W'(r_rem != '0);
                prim_v = 1'b1;
                prim.kind            = KIND_MESSAGE;
                prim.payload_byte    = i_byte;
                prim.message_index   = r_msg_count[7:0];
                prim.end_of_sequence = (n_rem == '0);
                if (n_rem == '0) begin
                    n_msg_count = r_msg_count + 1'b1;
                    n_phase     = PH_MSG_LEN;
                end
            end
            default: begin
                // drain: drop bytes until the last one
            end
        endcase

        if (hdr_done) begin
            prim_v = 1'b1;
            prim.kind            = KIND_HEADER;
            prim.seq_observed    = n_seq_obs;
            prim.sequence_number = n_seq;
            prim.peer_session    = n_sess_obs;
            prim.session_id      = n_sess;
            prim.interval        = n_interval;
            prim.unsent_count    = n_unsent;
        end

        verd.kind        = KIND_VERDICT;
        verd.last_of_run = 1'b1;
        if (n_err != VERDICT_OK) verd.verdict = n_err;
        else if (n_phase == PH_MSG_LEN) verd.verdict = VERDICT_OK;
        else verd.verdict = VERDICT_TRUNCATED;

        prim.last_of_run = !i_last;

        o_push = '0;
        if (i_accept) begin
            if (prim_v) begin
                o_push.v0 = 1'b1;
                o_push.r0 = prim;
                if (i_last) begin
                    o_push.v1 = 1'b1;
                    o_push.r1 = verd;
                end
            end else if (i_last) begin
                o_push.v0 = 1'b1;
                o_push.r0 = verd;
            end
        end

        // close the packet: back to reset values
        if (i_last) begin
            n_phase     = PH_FLAG;
            n_fbc       = '0;
            n_rem       = '0;
            n_msg_count = '0;
            n_flags     = '0;
            n_seq_obs   = '0;
            n_seq       = '0;
            n_sess_obs  = '0;
            n_sess      = '0;
            n_interval  = '0;
            n_unsent    = '0;
            n_err       = VERDICT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FLAG;
            r_fbc       <= '0;
            r_rem       <= '0;
            r_msg_count <= '0;
            r_flags     <= '0;
            r_seq_obs   <= '0;
            r_seq       <= '0;
            r_sess_obs  <= '0;
            r_sess      <= '0;
            r_interval  <= '0;
            r_unsent    <= '0;
            r_err       <= VERDICT_OK;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_fbc       <= n_fbc;
            r_rem       <= n_rem;
            r_msg_count <= n_msg_count;
            r_flags     <= n_flags;
            r_seq_obs   <= n_seq_obs;
            r_seq       <= n_seq;
            r_sess_obs  <= n_sess_obs;
            r_sess      <= n_sess;
            r_interval  <= n_interval;
            r_unsent    <= n_unsent;
            r_err       <= n_err;
        end
    end

    a_err_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != VERDICT_OK) |-> (r_phase == PH_DRAIN))
        else $error("error code set outside drain phase");

    a_rem_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_MISSED_BODY && r_phase != PH_MSG_BODY) |-> (r_rem == '0))
        else $error("remaining byte count nonzero outside a body");

    a_msg_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_msg_count <= MSG_CNT_W'(MAX_MESSAGES))
        else $error("message count beyond limit");

endmodule

/* rtl/php_out_queue.sv */
// Small result queue: takes up to two results per cycle, sends one per cycle while popped.
module php_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  php_pkg::t_push     i_push,
    input  logic               i_pop,
    output logic               o_valid,
    output php_pkg::t_result   o_result,
    output logic               o_room
);
    import php_pkg::*;

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count,  n_count;
    logic [QPTR_W-1:0]   wr_ptr1;
    logic                do_pop;

    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    // room for a full two-result burst
    assign o_room   = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign do_pop   = i_pop && o_valid;
    assign wr_ptr1  = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_push.v0) + QPTR_W'(i_push.v1);
        n_rd_ptr = r_rd_ptr + QPTR_W'(do_pop);
        n_count  = r_count + QCNT_W'(i_push.v0) + QCNT_W'(i_push.v1)
                   - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wr_ptr] <= i_push.r0;
        if (i_push.v1) r_mem[wr_ptr1]  <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> i_push.v0)
        else $error("second result pushed without first");

    a_pair_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> (r_count <= QCNT_W'(QUEUE_DEPTH - 2)))
        else $error("push without room for a two-result burst");

endmodule

/* rtl/packet_header_parser.sv */
// Top level of the packet header parser: byte stream in, result stream out.
// Each result word is registered in the result queue when its input byte is accepted.
// Throughput: one byte per cycle while the queue has room; a byte that yields two words
// (body or header plus verdict) has its extra word absorbed by a four-word result queue.
// Input is stalled only while the queue cannot take a two-word burst.
// Reset (i_rst_n low, synchronous) returns the parser to the flag byte and empties the queue.
module packet_header_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // slave side: packet bytes
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] packet_byte
    input  logic          s_axis_tlast,   // last_byte
    // master side: result words
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [7:0] seq_observed, [23:8] sequence_number, [55:24] peer_session,
    // [87:56] session_id, [95:88] interval, [103:96] unsent_count,
    // [111:104] payload_byte, [119:112] message_index, [120] end_of_sequence,
    // [122:121] verdict, [127:123] zero
    output logic [127:0]  m_axis_tdata,
    output logic [1:0]    m_axis_tuser,   // [1:0] kind
    output logic          m_axis_tlast    // last_of_run
);
    import php_pkg::*;

    logic    accept;
    logic    q_room;
    t_push   push;
    t_result res;

    // take a byte whenever the queue can hold the words it may produce
    assign s_axis_tready = q_room;
    assign accept        = s_axis_tvalid && q_room;

    php_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (push)
    );

    php_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (res),
        .o_room   (q_room)
    );

    // pack the result word, first field in the lowest bits
    assign m_axis_tdata = {5'b0,
                           res.verdict,
                           res.end_of_sequence,
                           res.message_index,
                           res.payload_byte,
                           res.unsent_count,
                           res.interval,
                           res.session_id,
                           res.peer_session,
                           res.sequence_number,
                           res.seq_observed};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last_of_run;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the packet header parser: byte stream in, checked result words out.
`timescale 1ns / 1ps

module tb_top;
    import php_pkg::*;

    localparam int ITEM_TARGET      = 1450;    // bytes to feed before stopping stimulus
    localparam int CYCLE_LIMIT      = 300000;  // watchdog, far above the slowest legal run
    localparam int SINK_HOLD_CYCLES = 60;      // long receiver stall, fills the result queue
    localparam int TAIL_CYCLES      = 8;       // settle time after the last expected word

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;    // [7:0] packet_byte
    logic         s_axis_tlast = 1'b0;     // last_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [7:0] seq_observed, [23:8] sequence_number, [55:24] peer_session,
    // [87:56] session_id, [95:88] interval, [103:96] unsent_count,
    // [111:104] payload_byte, [119:112] message_index, [120] end_of_sequence,
    // [122:121] verdict, [127:123] zero
    logic [127:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;            // [1:0] kind
    logic         m_axis_tlast;            // last_of_run

    packet_header_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Parser state as the testbench tracks it
    t_phase      p_phase = PH_FLAG;
    logic [1:0]  p_byte_idx = '0;
    logic [8:0]  p_body_left = '0;
    logic [8:0]  p_msgs_done = '0;
    logic [7:0]  p_flags = '0;
    logic [7:0]  p_seq_obs = '0;
    logic [15:0] p_seqn = '0;
    logic [31:0] p_sess_obs = '0;
    logic [31:0] p_sess = '0;
    logic [7:0]  p_interval = '0;
    logic [7:0]  p_unsent = '0;
    t_verdict    p_err = VERDICT_OK;

    t_result     due_results[$];   // words the parser still owes, oldest first
    t_result     run_results[$];   // words caused by the byte being parsed
    logic [7:0]  pkt_q[$];         // packet under construction

    int          mismatches = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    logic        steady = 1'b0;         // suppress random idling on both sides
    logic        sink_hold_req = 1'b0;  // ask the receiver for one long stall

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Idle cycles before a byte or after a received word; none during steady stretches
    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    // Length byte: mostly short bodies, now and then the longest one
    function automatic int draw_len();
        return ($urandom_range(0, 29) == 0) ? 255 : $urandom_range(0, 7);
    endfunction

    function automatic void clear_parse_state();
        p_phase     = PH_FLAG;
        p_byte_idx  = '0;
        p_body_left = '0;
        p_msgs_done = '0;
        p_flags     = '0;
        p_seq_obs   = '0;
        p_seqn      = '0;
        p_sess_obs  = '0;
        p_sess      = '0;
        p_interval  = '0;
        p_unsent    = '0;
        p_err       = VERDICT_OK;
    endfunction

    // Build one result word; header fields only travel with header words
    function automatic t_result make_result(t_kind k, logic [7:0] pay, logic [7:0] idx,
                                            logic eos, t_verdict v);
        t_result r;
        r = '0;
        r.kind = k;
        if (k == KIND_HEADER) begin
            r.seq_observed    = p_seq_obs;
            r.sequence_number = p_seqn;
            r.peer_session    = p_sess_obs;
            r.session_id      = p_sess;
            r.interval        = p_interval;
            r.unsent_count    = p_unsent;
        end
        r.payload_byte    = pay;
        r.message_index   = idx;
        r.end_of_sequence = eos;
        r.verdict         = v;
        return r;
    endfunction

    // Header field order; PH_MISSED_LEN stands for "header complete"
    function automatic t_phase following(t_phase p);
        case (p)
            PH_SEQ:      return PH_SESSOBS;
            PH_SESSOBS:  return PH_SESS;
            PH_SESS:     return PH_INTERVAL;
            PH_INTERVAL: return PH_UNSENT;
            default:     return PH_MISSED_LEN;
        endcase
    endfunction

    function automatic logic field_present(t_phase p);
        case (p)
            PH_SESSOBS:  return p_flags[FLAG_PEER_SESSION_BIT];
            PH_SESS:     return p_flags[FLAG_SESSION_BIT];
            PH_INTERVAL: return p_flags[FLAG_INTERVAL_BIT];
            PH_UNSENT:   return p_flags[FLAG_SENT_BIT];
            default:     return 1'b1;
        endcase
    endfunction

    // Skip absent fields; emit the header once no field is left
    function automatic void close_field(t_phase from);
        t_phase p;
        p = following(from);
        while (p != PH_MISSED_LEN && !field_present(p))
            p = following(p);
        p_byte_idx = '0;
        if (p != PH_MISSED_LEN) begin
            p_phase = p;
        end else begin
            run_results.push_back(make_result(KIND_HEADER, 8'h00, 8'h00, 1'b0, VERDICT_OK));
            p_phase = p_flags[FLAG_MISSED_BIT] ? PH_MISSED_LEN : PH_MSG_LEN;
        end
    endfunction

    // Advance the tracked parser by one accepted byte and queue the words it owes
    function automatic void parse_byte(logic [7:0] b, logic last);
        t_verdict v;
        t_result  tail;
        case (p_phase)
            PH_FLAG: begin
                clear_parse_state();
                p_flags = b;
                p_phase = PH_SEQOBS;
            end
            PH_SEQOBS: begin
                p_seq_obs  = b;
                p_phase    = PH_SEQ;
                p_byte_idx = '0;
            end
            PH_SEQ: begin
                p_seqn = {p_seqn[7:0], b};
                if (p_byte_idx >= SEQ_LAST_BYTE) close_field(PH_SEQ);
                else p_byte_idx++;
            end
            PH_SESSOBS: begin
                p_sess_obs = {p_sess_obs[23:0], b};
                if (p_byte_idx >= WORD_LAST_BYTE) close_field(PH_SESSOBS);
                else p_byte_idx++;
            end
            PH_SESS: begin
                p_sess = {p_sess[23:0], b};
                if (p_byte_idx >= WORD_LAST_BYTE) close_field(PH_SESS);
                else p_byte_idx++;
            end
            PH_INTERVAL: begin
                p_interval = b;
                close_field(PH_INTERVAL);
            end
            PH_UNSENT: begin
                p_unsent = b;
                close_field(PH_UNSENT);
            end
            PH_MISSED_LEN: begin
                p_body_left = b + 9'd1;
                p_phase     = PH_MISSED_BODY;
            end
            PH_MISSED_BODY: begin
                if (p_body_left > 0) p_body_left--;
                run_results.push_back(make_result(KIND_MISSED, b, 8'h00, p_body_left == 0,
                                                  VERDICT_OK));
                if (p_body_left == 0) p_phase = PH_MSG_LEN;
            end
            PH_MSG_LEN: begin
                // A length byte past the message limit poisons the rest of the packet
                if (p_msgs_done >= MAX_MESSAGES) begin
                    p_err   = VERDICT_TOO_MANY;
                    p_phase = PH_DRAIN;
                end else begin
                    p_body_left = b + 9'd1;
                    p_phase     = PH_MSG_BODY;
                end
            end
            PH_MSG_BODY: begin
                if (p_body_left > 0) p_body_left--;
                run_results.push_back(make_result(KIND_MESSAGE, b, p_msgs_done[7:0],
                                                  p_body_left == 0, VERDICT_OK));
                if (p_body_left == 0) begin
                    p_msgs_done++;
                    p_phase = PH_MSG_LEN;
                end
            end
            default: ;  // draining after an error: drop the byte
        endcase

        if (last) begin
            // Clean only when the packet ends between messages
            if (p_err != VERDICT_OK) v = p_err;
            else if (p_phase == PH_MSG_LEN) v = VERDICT_OK;
            else v = VERDICT_TRUNCATED;
            run_results.push_back(make_result(KIND_VERDICT, 8'h00, 8'h00, 1'b0, v));
            clear_parse_state();
        end

        if (run_results.size() > 0) begin
            tail = run_results.pop_back();
            tail.last_of_run = 1'b1;
            run_results.push_back(tail);
        end
        while (run_results.size() > 0)
            due_results.push_back(run_results.pop_front());
    endfunction

    // Offer one byte, hold it until accepted, then predict its words
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        parse_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt_q.size(); i++)
            send_byte(pkt_q[i], i == pkt_q.size() - 1);
        pkt_q.delete();
    endtask

    // Release the input and hold until every owed word has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // Length byte and len+1 random body bytes
    task automatic add_body(int len);
        int i;
        pkt_q.push_back(len[7:0]);
        for (i = 0; i <= len; i++) pkt_q.push_back(rand_byte());
    endtask

    // Flag byte plus every header field and missed list that the flags call for
    task automatic add_header(logic [7:0] flags);
        pkt_q.push_back(flags);
        repeat (3) pkt_q.push_back(rand_byte());
        if (flags[FLAG_PEER_SESSION_BIT]) repeat (4) pkt_q.push_back(rand_byte());
        if (flags[FLAG_SESSION_BIT]) repeat (4) pkt_q.push_back(rand_byte());
        if (flags[FLAG_INTERVAL_BIT]) pkt_q.push_back(rand_byte());
        if (flags[FLAG_SENT_BIT]) pkt_q.push_back(rand_byte());
        if (flags[FLAG_MISSED_BIT]) add_body(draw_len());
    endtask

    // Hand-picked packets: bare header, lone flag byte, every optional field
    task automatic test_directed();
        // Reserved flag bits only: header closes on the last byte, verdict ok
        pkt_q = '{8'hE0, 8'hFF, 8'hFF, 8'h00};
        send_packet();
        // Packet that ends on its flag byte: truncated, nothing else
        pkt_q = '{8'h00};
        send_packet();
        // All fields present, cut inside a message: body byte plus truncated verdict
        pkt_q = '{8'h1F, 8'h00, 8'h00, 8'h01,
                  8'hAA, 8'h55, 8'h00, 8'hFF,
                  8'h80, 8'h01, 8'h02, 8'h7F,
                  8'h00, 8'hFF, 8'h00, 8'hA5,
                  8'h01, 8'h3C};
        send_packet();
        wait_drained();
    endtask

    // Fill the message limit, then one length byte too many and some dropped bytes
    task automatic test_message_limit();
        int m;
        add_header(8'h00);
        for (m = 0; m < MAX_MESSAGES; m++)
            add_body(m == 5 ? 255 : 0);
        repeat (4) pkt_q.push_back(rand_byte());
        send_packet();
        wait_drained();
    endtask

    // Stall the receiver for a long stretch while bytes keep coming at full rate
    task automatic test_backpressure();
        int m;
        steady = 1'b1;
        pkt_q.push_back(8'h1 << FLAG_MISSED_BIT);
        repeat (3) pkt_q.push_back(rand_byte());
        add_body(15);
        for (m = 0; m < 4; m++) add_body(7);
        sink_hold_req = 1'b1;
        send_packet();
        wait_drained();
        steady = 1'b0;
    endtask

    // Mostly well-formed packets with random flags, some cut short, some raw noise
    task automatic test_random_packets();
        int shape;
        int n_msgs;
        int keep;
        int m;
        while (bytes_sent < ITEM_TARGET) begin
            steady = ($urandom_range(0, 4) == 0);
            shape  = $urandom_range(0, 9);
            if (shape == 9) begin
                repeat ($urandom_range(1, 12)) pkt_q.push_back(rand_byte());
            end else begin
                add_header(rand_byte());
                n_msgs = $urandom_range(0, 4);
                for (m = 0; m < n_msgs; m++) add_body(draw_len());
                if (shape >= 7) begin
                    // Cut anywhere before the natural end
                    keep = $urandom_range(1, pkt_q.size() - 1);
                    while (pkt_q.size() > keep) void'(pkt_q.pop_back());
                end
            end
            send_packet();
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        steady = 1'b0;
        wait_drained();
    endtask

    // Receiver: random stall after each word, one long hold on request
    initial begin : result_sink
        int pause;
        wait (i_rst_n);
        @(posedge i_clk);
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                pause = draw_gap();
                if (pause > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (pause) @(posedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare every accepted word against the oldest owed one
    always @(posedge i_clk) begin : result_check
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind            = t_kind'(m_axis_tuser);
            got.seq_observed    = m_axis_tdata[7:0];
            got.sequence_number = m_axis_tdata[23:8];
            got.peer_session    = m_axis_tdata[55:24];
            got.session_id      = m_axis_tdata[87:56];
            got.interval        = m_axis_tdata[95:88];
            got.unsent_count    = m_axis_tdata[103:96];
            got.payload_byte    = m_axis_tdata[111:104];
            got.message_index   = m_axis_tdata[119:112];
            got.end_of_sequence = m_axis_tdata[120];
            got.verdict         = t_verdict'(m_axis_tdata[122:121]);
            got.last_of_run     = m_axis_tlast;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected word, expected none, got kind %0d data %0h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(got.kind));
                check_field("seq_observed", 32'(want.seq_observed),
                            32'(got.seq_observed));
                check_field("sequence_number", 32'(want.sequence_number),
                            32'(got.sequence_number));
                check_field("peer_session", want.peer_session, got.peer_session);
                check_field("session_id", want.session_id, got.session_id);
                check_field("interval", 32'(want.interval), 32'(got.interval));
                check_field("unsent_count", 32'(want.unsent_count),
                            32'(got.unsent_count));
                check_field("payload_byte", 32'(want.payload_byte),
                            32'(got.payload_byte));
                check_field("message_index", 32'(want.message_index),
                            32'(got.message_index));
                check_field("end_of_sequence", 32'(want.end_of_sequence),
                            32'(got.end_of_sequence));
                check_field("verdict", 32'(want.verdict), 32'(got.verdict));
                check_field("last_of_run", 32'(want.last_of_run),
                            32'(got.last_of_run));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_message_limit();
        test_backpressure();
        test_random_packets();
        // Let any stray word surface before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
